### rtl/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared constants and types of the contiguous fit allocator: command,
// placement mode and status codes, field widths and the scan control group.
// ----------------------------------------------------------------------------
`default_nettype none

package cfa_pkg;

    // default number of cells in the occupancy map
    localparam int unsigned C_CELLS = 2048;

    // transaction field widths
    localparam int unsigned C_LEN_W   = 12;
    localparam int unsigned C_START_W = 11;
    localparam int unsigned C_MODE_W  = 2;
    localparam int unsigned C_STAT_W  = 2;

    // commands
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // placement modes, the unused code acts as first fit
    localparam logic [C_MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [C_MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [C_MODE_W-1:0] MODE_NEXT  = 2'd2;

    // result status codes
    localparam logic [C_STAT_W-1:0] ST_DONE   = 2'd0;
    localparam logic [C_STAT_W-1:0] ST_NO_FIT = 2'd1;
    localparam logic [C_STAT_W-1:0] ST_RANGE  = 2'd2;

    // control from the sequencer to the run tracking unit
    typedef struct packed {
        logic clear;    // drop run and best hole, start a new pass
        logic valid;    // a bitmap cell is presented this cycle
        logic free;     // the presented cell is free
        logic last;     // the presented cell is the last one of the map
    } t_scan_ctl;

endpackage

`default_nettype wire

### rtl/cfa_bitmap.sv
// ----------------------------------------------------------------------------
// cfa_bitmap
// Occupancy bitmap memory, one bit per cell, one write port and one read
// port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_bitmap
    import cfa_pkg::*;
#(
    parameter int unsigned P_CELLS = C_CELLS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(P_CELLS)-1:0] i_waddr,
    input  wire logic                       i_wdata,
    input  wire logic [$clog2(P_CELLS)-1:0] i_raddr,
    output logic                            o_rdata
);

    logic r_mem [P_CELLS];
    logic r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/cfa_scan.sv
// ----------------------------------------------------------------------------
// cfa_scan
// Run tracking unit shared by all placement modes. Takes one bitmap cell per
// valid cycle, counts the current free run, flags when it reaches the requested
// length and keeps the smallest sufficient hole seen in the pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_scan
    import cfa_pkg::*;
#(
    parameter int unsigned P_CELLS = C_CELLS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_scan_ctl                    i_ctl,
    input  wire logic [$clog2(P_CELLS)-1:0]   i_addr,
    input  wire logic [$clog2(P_CELLS+1)-1:0] i_len,
    output logic                              o_hit,
    output logic [$clog2(P_CELLS)-1:0]        o_hit_start,
    output logic                              o_found,
    output logic [$clog2(P_CELLS)-1:0]        o_best_start
);

    localparam int unsigned AW = $clog2(P_CELLS);
    localparam int unsigned CW = $clog2(P_CELLS + 1);

    logic [CW-1:0] r_run_len;
    logic [AW-1:0] r_run_start;
    logic          r_found;
    logic [CW-1:0] r_best;
    logic [AW-1:0] r_best_start;

    logic [CW-1:0] n_run_len;
    logic [AW-1:0] n_run_start;
    logic          hole_end;
    logic [CW-1:0] hole_size;
    logic [AW-1:0] hole_start;
    logic          take_hole;

    // extend or break the current free run
    always_comb begin
        n_run_len   = i_ctl.free ? (r_run_len + CW'(1)) : '0;
        n_run_start = (i_ctl.free && (r_run_len == '0)) ? i_addr : r_run_start;
    end

    // hole ends on a used cell after a free run, or at the end of the map
    always_comb begin
        hole_end   = i_ctl.valid && ((!i_ctl.free && (r_run_len != '0)) ||
                                     (i_ctl.free && i_ctl.last));
        hole_size  = i_ctl.free ? n_run_len : r_run_len;
        hole_start = i_ctl.free ? n_run_start : r_run_start;
        take_hole  = hole_end && (hole_size >= i_len) &&
                     (!r_found || (hole_size < r_best));
    end

    // run and best hole registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_run_len <= '0;
            r_found   <= 1'b0;
        end else if (i_ctl.valid) begin
            r_run_len <= n_run_len;
            if (take_hole) begin
                r_found <= 1'b1;
            end
        end
    end

    // payload of the run tracker
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_run_start <= n_run_start;
            if (take_hole) begin
                r_best       <= hole_size;
                r_best_start <= hole_start;
            end
        end
    end

    // the run has reached the requested length
    assign o_hit        = i_ctl.valid && i_ctl.free && (n_run_len >= i_len);
    assign o_hit_start  = n_run_start;
    assign o_found      = r_found;
    assign o_best_start = r_best_start;

endmodule

`default_nettype wire

### rtl/contiguous_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// contiguous_fit_allocator_core
// Contiguous run allocator over an occupancy bitmap with first, best and
// next fit placement, and release of a given run.
// ----------------------------------------------------------------------------
// Sequence: a rejected request reports in the cycle after start; a release
//   clears its run_length cells; an allocate scans one cell a cycle (next fit
//   from its resume cell to the end, then again from cell zero; best fit always
//   the whole map), then marks run_length cells, one a cycle.
// Throughput: one transaction at a time, busy stays high until the result.
// Reset: a clearing pass over all cells frees the bitmap; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_fit_allocator_core
    import cfa_pkg::*;
#(
    parameter int unsigned P_CELLS = C_CELLS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // command channel
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_command,
    input  wire logic [$clog2(P_CELLS+1)-1:0]   i_run_length,
    input  wire logic [$clog2(P_CELLS)-1:0]     i_release_start,
    // result channel
    output logic                                o_result_valid,
    output logic [C_STAT_W-1:0]                 o_status,
    output logic [$clog2(P_CELLS)-1:0]          o_run_start,
    // configuration channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [C_MODE_W-1:0]            i_cfg_fit_mode
);

    localparam int unsigned AW = $clog2(P_CELLS);
    localparam int unsigned CW = $clog2(P_CELLS + 1);
    localparam int unsigned EW = ((CW > C_LEN_W) ? CW : C_LEN_W) + 1;

    localparam logic [AW-1:0] LAST_CELL = AW'(P_CELLS - 1);
    localparam logic [AW:0]   CELLS_P   = (AW+1)'(P_CELLS);
    localparam logic [EW-1:0] CELLS_E   = EW'(P_CELLS);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_WRAP   = 6'b001000,
        S_DECIDE = 6'b010000,
        S_MARK   = 6'b100000
    } t_state;

    t_state              r_state;
    logic [C_MODE_W-1:0] r_fit_mode;
    logic [AW-1:0]       r_next_pos;
    logic [CW-1:0]       r_len;
    logic [AW-1:0]       r_raddr;
    logic                r_issue;
    logic                r_dvalid;
    logic [AW-1:0]       r_daddr;
    logic                r_wrapped;
    logic [AW:0]         r_wptr;
    logic [CW-1:0]       r_remain;
    logic                r_is_alloc;
    logic [AW-1:0]       r_where;
    logic                r_res_valid;
    logic [C_STAT_W-1:0] r_status;
    logic [AW-1:0]       r_run_start;

    logic                mode_best;
    logic                mode_next;
    logic [EW-1:0]       len_ext;
    logic                alloc_bad;
    logic                release_bad;
    logic [AW:0]         end_sum;
    logic [AW:0]         end_wrap;
    logic                rdata;
    logic                mem_we;
    logic                mem_wdata;
    t_scan_ctl           scan_ctl;
    logic                hit;
    logic [AW-1:0]       hit_start;
    logic                found;
    logic [AW-1:0]       best_start;

    // mode decode, the unused code falls to first fit
    assign mode_best = (r_fit_mode == MODE_BEST);
    assign mode_next = (r_fit_mode == MODE_NEXT);

    // request range checks
    always_comb begin
        len_ext     = EW'(i_run_length);
        alloc_bad   = (len_ext == '0) || (len_ext > CELLS_E);
        release_bad = (len_ext == '0) || ((EW'(i_release_start) + len_ext) > CELLS_E);
    end

    // next fit position after the last marked cell, modulo the map size
    always_comb begin
        end_sum  = r_wptr + (AW+1)'(1);
        end_wrap = (end_sum >= CELLS_P) ? (end_sum - CELLS_P) : end_sum;
    end

    // configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= MODE_FIRST;
        end else if (i_cfg_valid) begin
            r_fit_mode <= i_cfg_fit_mode;
        end
    end

    // bitmap write side: clearing pass and run marking
    assign mem_we    = (r_state == S_CLEAR) || (r_state == S_MARK);
    assign mem_wdata = (r_state == S_MARK) && r_is_alloc;

    cfa_bitmap #(
        .P_CELLS (P_CELLS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wptr[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (r_raddr),
        .o_rdata (rdata)
    );

    // run tracking unit fed with the registered read data
    always_comb begin
        scan_ctl.clear = (r_state != S_SCAN);
        scan_ctl.valid = r_dvalid;
        scan_ctl.free  = !rdata;
        scan_ctl.last  = (r_daddr == LAST_CELL);
    end

    cfa_scan #(
        .P_CELLS (P_CELLS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (scan_ctl),
        .i_addr       (r_daddr),
        .i_len        (r_len),
        .o_hit        (hit),
        .o_hit_start  (hit_start),
        .o_found      (found),
        .o_best_start (best_start)
    );

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_wptr      <= '0;
            r_issue     <= 1'b0;
            r_dvalid    <= 1'b0;
            r_res_valid <= 1'b0;
            r_next_pos  <= '0;
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_wptr <= r_wptr + (AW+1)'(1);
                    if (r_wptr == (AW+1)'(P_CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_issue  <= 1'b0;
                    r_dvalid <= 1'b0;
                    if (start) begin
                        if (i_command == CMD_ALLOC) begin
                            if (alloc_bad) begin
                                r_res_valid <= 1'b1;
                            end else begin
                                r_issue <= 1'b1;
                                r_state <= S_SCAN;
                            end
                        end else begin
                            if (release_bad) begin
                                r_res_valid <= 1'b1;
                            end else begin
                                r_wptr  <= (AW+1)'(i_release_start);
                                r_state <= S_MARK;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    r_dvalid <= r_issue;
                    if (r_raddr == LAST_CELL) begin
                        r_issue <= 1'b0;
                    end
                    if (hit && !mode_best) begin
                        r_wptr   <= {1'b0, hit_start};
                        r_issue  <= 1'b0;
                        r_dvalid <= 1'b0;
                        r_state  <= S_MARK;
                    end else if (r_dvalid && scan_ctl.last) begin
                        r_issue  <= 1'b0;
                        r_dvalid <= 1'b0;
                        if (mode_best) begin
                            r_state <= S_DECIDE;
                        end else if (mode_next && !r_wrapped) begin
                            r_state <= S_WRAP;
                        end else begin
                            r_res_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                S_WRAP: begin
                    r_issue <= 1'b1;
                    r_state <= S_SCAN;
                end
                S_DECIDE: begin
                    if (found) begin
                        r_wptr  <= {1'b0, best_start};
                        r_state <= S_MARK;
                    end else begin
                        r_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_MARK: begin
                    r_wptr <= r_wptr + (AW+1)'(1);
                    if (r_remain == CW'(1)) begin
                        if (r_is_alloc) begin
                            r_next_pos <= end_wrap[AW-1:0];
                        end
                        r_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // sequencer payload: read address, lengths and result fields
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_wrapped  <= 1'b0;
                r_len      <= CW'(len_ext);
                r_remain   <= CW'(len_ext);
                r_is_alloc <= (i_command == CMD_ALLOC);
                r_raddr    <= mode_next ? r_next_pos : '0;
                r_status   <= ST_RANGE;
                r_run_start <= '0;
                if (!alloc_bad && (i_command == CMD_ALLOC)) begin
                    r_status <= ST_NO_FIT;
                end
            end
            S_SCAN: begin
                r_daddr <= r_raddr;
                if (r_issue && (r_raddr != LAST_CELL)) begin
                    r_raddr <= r_raddr + AW'(1);
                end
                if (hit && !mode_best) begin
                    r_where <= hit_start;
                end
            end
            S_WRAP: begin
                r_wrapped <= 1'b1;
                r_raddr   <= '0;
            end
            S_DECIDE: begin
                r_where <= best_start;
            end
            S_MARK: begin
                r_remain <= r_remain - CW'(1);
                if (r_remain == CW'(1)) begin
                    r_status    <= ST_DONE;
                    r_run_start <= r_is_alloc ? r_where : '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_status       = r_status;
    assign o_run_start    = r_run_start;

    // the result strobe only ever appears with the block idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // an accepted transaction either starts work or reports at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("accepted transaction dropped");

    // marking never writes beyond the last cell
    a_mark_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> (r_wptr < CELLS_P))
        else $error("mark write beyond map end");

    // a failed or rejected request reports start cell zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status != ST_DONE)) |-> (o_run_start == '0))
        else $error("nonzero start on failed request");

endmodule

`default_nettype wire

### verif/tb_contiguous_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_contiguous_fit_allocator_core
// Self-checking bench for the contiguous fit allocator. A directed sequence
// hits range errors, a full map, no-fit and each placement mode. Random
// allocate and release traffic then follows under several modes and pacing
// settings. A bitmap predictor computes status and start for every accepted
// transaction and the monitor compares each result strobe in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_contiguous_fit_allocator_core;
    import cfa_pkg::*;

    // the reserved mode code, expected to place like first fit
    localparam logic [C_MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int unsigned PHASES = 8;
    localparam int unsigned PHASE_ITEMS = 34;

    typedef enum logic [1:0] {
        K_ITEM,
        K_MODE,
        K_DRAIN,
        K_PACE
    } t_kind;

    // one pending entry of the stimulus queue
    typedef struct {
        t_kind                kind;
        logic                 cmd;
        logic [C_LEN_W-1:0]   len;
        logic [C_START_W-1:0] first;
        int unsigned          val;
    } t_entry;

    typedef struct {
        logic [C_STAT_W-1:0]  status;
        logic [C_START_W-1:0] run_start;
    } t_outcome;

    // a run placed by the allocator, kept as a release candidate
    typedef struct {
        int unsigned first;
        int unsigned cells;
    } t_span;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_command = CMD_ALLOC;
    logic [C_LEN_W-1:0]   i_run_length = '0;
    logic [C_START_W-1:0] i_release_start = '0;
    logic                 o_result_valid;
    logic [C_STAT_W-1:0]  o_status;
    logic [C_START_W-1:0] o_run_start;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [C_MODE_W-1:0]  i_cfg_fit_mode = MODE_FIRST;

    // stimulus, expectations and predictor state
    t_entry               item_q[$];
    t_outcome             outcome_q[$];
    t_span                live_runs[$];
    bit                   cell_used [C_CELLS];
    int unsigned          hole_len [C_CELLS];
    logic [C_MODE_W-1:0]  placement_mode = MODE_FIRST;
    logic [C_START_W-1:0] resume_cell = '0;
    int unsigned          send_gap_pct = 0;
    int unsigned          mismatch_cnt = 0;

    contiguous_fit_allocator_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_run_length    (i_run_length),
        .i_release_start (i_release_start),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_run_start     (o_run_start),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_fit_mode  (i_cfg_fit_mode)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // search the predicted map for a hole under the current placement mode
    function automatic bit find_hole(input int unsigned len, output int unsigned where);
        int          j;
        int unsigned run;
        int unsigned i;
        int unsigned k;
        int unsigned best_sz;
        bit          hit;
        run = 0;
        hit = 1'b0;
        best_sz = 0;
        where = 0;
        for (j = C_CELLS - 1; j >= 0; j--) begin
            run = cell_used[j] ? 0 : run + 1;
            hole_len[j] = run;
        end
        if (placement_mode == MODE_BEST) begin
            // walk hole by hole, keep the smallest one that fits
            i = 0;
            while (i < C_CELLS) begin
                if (hole_len[i] == 0) begin
                    i++;
                end else begin
                    if (hole_len[i] >= len && (!hit || hole_len[i] < best_sz)) begin
                        best_sz = hole_len[i];
                        where = i;
                        hit = 1'b1;
                    end
                    i += hole_len[i];
                end
            end
        end else if (placement_mode == MODE_NEXT) begin
            // candidate starts from the resume cell, wrapping to cell zero
            for (k = 0; k < C_CELLS && !hit; k++) begin
                i = (resume_cell + k) % C_CELLS;
                if (hole_len[i] >= len) begin
                    where = i;
                    hit = 1'b1;
                end
            end
        end else begin
            for (i = 0; i < C_CELLS && !hit; i++) begin
                if (hole_len[i] >= len) begin
                    where = i;
                    hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    // apply one accepted transaction to the predicted map, queue its outcome
    function automatic void predict_item(input logic cmd, input int unsigned len,
                                         input int unsigned first);
        t_outcome    o;
        int unsigned at;
        int unsigned i;
        t_span       s;
        o.status = ST_DONE;
        o.run_start = '0;
        if (cmd == CMD_ALLOC) begin
            if (len == 0 || len > C_CELLS) begin
                o.status = ST_RANGE;
            end else if (find_hole(len, at)) begin
                for (i = 0; i < len; i++)
                    cell_used[at + i] = 1'b1;
                resume_cell = C_START_W'((at + len) % C_CELLS);
                o.run_start = C_START_W'(at);
                s.first = at;
                s.cells = len;
                live_runs.push_back(s);
            end else begin
                o.status = ST_NO_FIT;
            end
        end else begin
            if (len == 0 || first + len > C_CELLS) begin
                o.status = ST_RANGE;
            end else begin
                for (i = 0; i < len; i++)
                    cell_used[first + i] = 1'b0;
            end
        end
        outcome_q.push_back(o);
    endfunction

    function automatic void push_entry(input t_kind kind, input logic cmd,
                                       input int unsigned len, input int unsigned first,
                                       input int unsigned val);
        t_entry e;
        e.kind = kind;
        e.cmd = cmd;
        e.len = C_LEN_W'(len);
        e.first = C_START_W'(first);
        e.val = val;
        item_q.push_back(e);
    endfunction

    // driver: presents queued transactions, mode writes only while quiet
    always @(posedge i_clk) begin : drive
        logic   nxt_start;
        logic   nxt_cfg_valid;
        logic   quiet;
        t_entry head;
        nxt_start = start;
        nxt_cfg_valid = i_cfg_valid;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
            nxt_cfg_valid = 1'b0;
        end else begin
            // quiet means no transaction in flight and no result pending
            quiet = (outcome_q.size() == 0) && !o_result_valid;
            if (start && !busy) begin
                predict_item(i_command, 32'(i_run_length), 32'(i_release_start));
                nxt_start = 1'b0;
                quiet = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                placement_mode = i_cfg_fit_mode;
                nxt_cfg_valid = 1'b0;
            end
            if (!nxt_start && !nxt_cfg_valid && item_q.size() > 0) begin
                head = item_q[0];
                case (head.kind)
                    K_ITEM: begin
                        if ($urandom_range(99) >= send_gap_pct) begin
                            void'(item_q.pop_front());
                            nxt_start = 1'b1;
                            i_command <= head.cmd;
                            i_run_length <= head.len;
                            i_release_start <= head.first;
                        end
                    end
                    K_MODE: begin
                        if (quiet) begin
                            void'(item_q.pop_front());
                            nxt_cfg_valid = 1'b1;
                            i_cfg_fit_mode <= C_MODE_W'(head.val);
                        end
                    end
                    K_DRAIN: begin
                        if (quiet)
                            void'(item_q.pop_front());
                    end
                    default: begin
                        send_gap_pct = head.val;
                        void'(item_q.pop_front());
                    end
                endcase
            end
        end
        start <= nxt_start;
        i_cfg_valid <= nxt_cfg_valid;
    end

    // monitor: every strobe is checked against the oldest outcome
    always @(posedge i_clk) begin : check
        t_outcome want;
        if (i_rst_n && o_result_valid) begin
            if (outcome_q.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("unexpected result: status %0d run_start %0d",
                             o_status, o_run_start);
                mismatch_cnt++;
            end else begin
                want = outcome_q.pop_front();
                if (o_status !== want.status || o_run_start !== want.run_start) begin
                    if (mismatch_cnt < 10)
                        $display("mismatch: status exp %0d got %0d, run_start exp %0d got %0d",
                                 want.status, o_status, want.run_start, o_run_start);
                    mismatch_cnt++;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        logic [C_MODE_W-1:0] mode_plan [PHASES];
        int unsigned         pace_plan [PHASES];
        int unsigned         roll;
        int unsigned         len;
        int unsigned         first;
        int unsigned         idx;
        int unsigned         p;
        int unsigned         n;
        mode_plan = '{MODE_FIRST, MODE_BEST, MODE_NEXT, MODE_SPARE,
                      MODE_NEXT, MODE_BEST, MODE_FIRST, MODE_NEXT};
        pace_plan = '{0, 82, 25, 0, 82, 25, 0, 82};

        // range errors, a release of free cells, full map and no fit
        push_entry(K_ITEM, CMD_ALLOC, 0, 0, 0);
        push_entry(K_ITEM, CMD_ALLOC, C_CELLS + 1, 0, 0);
        push_entry(K_ITEM, CMD_ALLOC, 4095, 2047, 0);
        push_entry(K_ITEM, CMD_RELEASE, 0, 0, 0);
        push_entry(K_ITEM, CMD_RELEASE, 2, 2047, 0);
        push_entry(K_ITEM, CMD_RELEASE, 1, 2047, 0);
        push_entry(K_ITEM, CMD_ALLOC, C_CELLS, 0, 0);
        push_entry(K_ITEM, CMD_ALLOC, 1, 0, 0);
        push_entry(K_ITEM, CMD_RELEASE, C_CELLS, 0, 0);
        // two holes of 100 and 70 cells ahead of the free tail
        push_entry(K_ITEM, CMD_ALLOC, 100, 0, 0);
        push_entry(K_ITEM, CMD_ALLOC, 10, 0, 0);
        push_entry(K_ITEM, CMD_ALLOC, 70, 0, 0);
        push_entry(K_ITEM, CMD_ALLOC, 10, 0, 0);
        push_entry(K_ITEM, CMD_RELEASE, 100, 0, 0);
        push_entry(K_ITEM, CMD_RELEASE, 70, 110, 0);
        // best fit takes the smaller hole
        push_entry(K_MODE, CMD_ALLOC, 0, 0, 32'(MODE_BEST));
        push_entry(K_ITEM, CMD_ALLOC, 60, 0, 0);
        // next fit resumes after the last run, then wraps to cell zero
        push_entry(K_MODE, CMD_ALLOC, 0, 0, 32'(MODE_NEXT));
        push_entry(K_ITEM, CMD_ALLOC, 5, 0, 0);
        push_entry(K_ITEM, CMD_ALLOC, 1858, 0, 0);
        push_entry(K_ITEM, CMD_ALLOC, 8, 0, 0);
        // reserved mode places like first fit
        push_entry(K_MODE, CMD_ALLOC, 0, 0, 32'(MODE_SPARE));
        push_entry(K_ITEM, CMD_ALLOC, 20, 0, 0);
        push_entry(K_ITEM, CMD_RELEASE, C_CELLS, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // random traffic, one mode and pacing per phase
        for (p = 0; p < PHASES; p++) begin
            push_entry(K_MODE, CMD_ALLOC, 0, 0, 32'(mode_plan[p]));
            push_entry(K_PACE, CMD_ALLOC, 0, 0, pace_plan[p]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                while (item_q.size() >= 2)
                    @(negedge i_clk);
                if (p == 2 && n == PHASE_ITEMS / 2)
                    push_entry(K_DRAIN, CMD_ALLOC, 0, 0, 0);
                roll = $urandom_range(99);
                if (roll < 55) begin
                    // mostly short runs, a few large ones
                    roll = $urandom_range(99);
                    if (roll < 90)
                        len = $urandom_range(48, 1);
                    else if (roll < 97)
                        len = $urandom_range(600, 49);
                    else
                        len = $urandom_range(C_CELLS, 601);
                    push_entry(K_ITEM, CMD_ALLOC, len, $urandom(), 0);
                end else if (roll < 88 && live_runs.size() > 0) begin
                    idx = $urandom_range(live_runs.size() - 1);
                    push_entry(K_ITEM, CMD_RELEASE, live_runs[idx].cells,
                               live_runs[idx].first, 0);
                    live_runs.delete(idx);
                end else begin
                    case ($urandom_range(3))
                        0: push_entry(K_ITEM, CMD_RELEASE, $urandom_range(64, 1),
                                      $urandom(), 0);
                        1: push_entry(K_ITEM, 1'($urandom_range(1)), 0, $urandom(), 0);
                        2: push_entry(K_ITEM, CMD_ALLOC, $urandom_range(4095, C_CELLS + 1),
                                      $urandom(), 0);
                        default: begin
                            // release that runs past the last cell
                            first = $urandom_range(C_CELLS - 1, C_CELLS - 64);
                            len = $urandom_range(C_CELLS - first + 64, C_CELLS - first + 1);
                            push_entry(K_ITEM, CMD_RELEASE, len, first, 0);
                        end
                    endcase
                end
            end
        end

        // drain, then allow for any stray strobe
        while (item_q.size() != 0 || start || i_cfg_valid || outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (64) @(negedge i_clk);
        if (mismatch_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/cfa_pkg.sv
rtl/cfa_bitmap.sv
rtl/cfa_scan.sv
rtl/contiguous_fit_allocator_core.sv
verif/tb_contiguous_fit_allocator_core.sv
